// ===== sv/gzhp_pkg.sv =====
package gzhp_pkg;

  // Status codes returned with every byte.
  typedef enum logic [2:0] {
    ST_MORE      = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_BADMAGIC  = 3'd2,
    ST_BADMETHOD = 3'd3,
    ST_TRUNC     = 3'd4
  } status_e;

  // Fixed header bytes.
  localparam logic [7:0] MagicByte0  = 8'h1f;
  localparam logic [7:0] MagicByte1  = 8'h8b;
  localparam logic [7:0] MethodByte  = 8'h08;

  // Flag bits.
  localparam int unsigned FlagHcrcBit  = 1;
  localparam int unsigned FlagExtraBit = 2;
  localparam int unsigned FlagNameBit  = 3;
  localparam int unsigned FlagCommBit  = 4;

  // Bytes of mtime, xfl and os after the flag byte.
  localparam logic [15:0] FixedBytes = 16'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
    logic       begin_req;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] header_flags;
  } out_item_t;

  // One byte handed from the input register to the header walker.
  typedef struct packed {
    logic     fire;
    in_item_t item;
  } walk_req_t;

endpackage

// ===== sv/gzip_header_parser.sv =====
// Channel  Direction  Payload                  Handshake
// in       input      gzhp_pkg::in_item_t      in_valid_i / in_stall_o
// out      output     gzhp_pkg::out_item_t     out_valid_o / out_stall_i
//
// Each byte passes from input transfer through the input register and then the
// result register. The walker state updates as the byte moves from the input
// register into the result register.
// A new byte is taken every cycle while the output is not stalled.
// Reset clears the valid bits and puts the walker back at the first magic byte.
// A stall on the output holds the result and then the input register in place.
module gzip_header_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gzhp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gzhp_pkg::out_item_t out_data_o
);

  logic                in_valid_q;
  gzhp_pkg::in_item_t  in_q;
  logic                out_valid_q;
  gzhp_pkg::out_item_t out_q;
  logic                advance;
  gzhp_pkg::walk_req_t walk_req;
  gzhp_pkg::out_item_t walk_result;

  // The result register can take a new result when it is empty or being
  // drained this cycle; the input register then empties into it.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  assign walk_req.fire = in_valid_q && advance;
  assign walk_req.item = in_q;

  gzhp_walker u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (walk_req),
    .result_o (walk_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_data_i;
    if (walk_req.fire) out_q <= walk_result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A held byte in the input register moves on as soon as the output drains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_stall_i) |=> out_valid_q)
    else $error("byte lost between input and result registers");

  // The input side stalls only while it holds a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled without a reason");

  // Results carry a defined status code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.status <= gzhp_pkg::ST_TRUNC))
    else $error("undefined status code");

endmodule

// ===== sv/gzhp_walker.sv =====
module gzhp_walker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gzhp_pkg::walk_req_t req_i,
  output gzhp_pkg::out_item_t result_o
);

  typedef enum logic [3:0] {
    PH_MAGIC0,
    PH_MAGIC1,
    PH_METHOD,
    PH_FLAGS,
    PH_FIXED,
    PH_XLEN0,
    PH_XLEN1,
    PH_XDATA,
    PH_NAME,
    PH_COMMENT,
    PH_HCRC0,
    PH_HCRC1,
    PH_DONE
  } phase_e;

  // Sections of the header that can be finished: fixed bytes, extra, name, comment.
  typedef enum logic [1:0] {
    PART_FIXED,
    PART_EXTRA,
    PART_NAME,
    PART_COMMENT
  } part_e;

  phase_e             phase_q, phase_d;
  logic [15:0]        skip_q, skip_d;
  logic [7:0]         flags_q, flags_d;
  logic [7:0]         len_low_q, len_low_d;
  gzhp_pkg::status_e  outcome_q, outcome_d;

  // First optional section that follows the one just finished, or the done phase if none is left.
  function automatic phase_e next_part(part_e done, logic [7:0] flags);
    phase_e ph;
    if (done == PART_FIXED && flags[gzhp_pkg::FlagExtraBit]) begin
      ph = PH_XLEN0;
    end else if ((done == PART_FIXED || done == PART_EXTRA) &&
                 flags[gzhp_pkg::FlagNameBit]) begin
      ph = PH_NAME;
    end else if (done != PART_COMMENT && flags[gzhp_pkg::FlagCommBit]) begin
      ph = PH_COMMENT;
    end else if (flags[gzhp_pkg::FlagHcrcBit]) begin
      ph = PH_HCRC0;
    end else begin
      ph = PH_DONE;
    end
    return ph;
  endfunction

  phase_e             base_phase;
  logic [15:0]        base_skip;
  logic [7:0]         base_flags;
  logic [7:0]         base_len_low;
  gzhp_pkg::status_e  base_outcome;
  logic [15:0]        skip_dec;
  logic [15:0]        xlen;
  logic [7:0]         b;

  always_comb begin
    // A begin request restarts the walk before the byte is looked at.
    if (req_i.item.begin_req) begin
      base_phase   = PH_MAGIC0;
      base_skip    = '0;
      base_flags   = '0;
      base_len_low = '0;
      base_outcome = gzhp_pkg::ST_MORE;
    end else begin
      base_phase   = phase_q;
      base_skip    = skip_q;
      base_flags   = flags_q;
      base_len_low = len_low_q;
      base_outcome = outcome_q;
    end

    b        = req_i.item.data_byte;
    skip_dec = base_skip - 16'd1;
    xlen     = {b, base_len_low};

    phase_d   = base_phase;
    skip_d    = base_skip;
    flags_d   = base_flags;
    len_low_d = base_len_low;
    outcome_d = base_outcome;

    if (base_outcome == gzhp_pkg::ST_MORE) begin
      if (req_i.item.end_of_stream) begin
        outcome_d = gzhp_pkg::ST_TRUNC;
      end else begin
        unique case (base_phase)
          PH_MAGIC0: begin
            if (b == gzhp_pkg::MagicByte0) phase_d = PH_MAGIC1;
            else outcome_d = gzhp_pkg::ST_BADMAGIC;
          end
          PH_MAGIC1: begin
            if (b == gzhp_pkg::MagicByte1) phase_d = PH_METHOD;
            else outcome_d = gzhp_pkg::ST_BADMAGIC;
          end
          PH_METHOD: begin
            if (b == gzhp_pkg::MethodByte) phase_d = PH_FLAGS;
            else outcome_d = gzhp_pkg::ST_BADMETHOD;
          end
          PH_FLAGS: begin
            flags_d = b;
            skip_d  = gzhp_pkg::FixedBytes;
            phase_d = PH_FIXED;
          end
          PH_FIXED: begin
            skip_d = skip_dec;
            if (skip_dec == '0) phase_d = next_part(PART_FIXED, base_flags);
          end
          PH_XLEN0: begin
            len_low_d = b;
            phase_d   = PH_XLEN1;
          end
          PH_XLEN1: begin
            skip_d = xlen;
            if (xlen == '0) phase_d = next_part(PART_EXTRA, base_flags);
            else phase_d = PH_XDATA;
          end
          PH_XDATA: begin
            skip_d = skip_dec;
            if (skip_dec == '0) phase_d = next_part(PART_EXTRA, base_flags);
          end
          PH_NAME: begin
            if (b == '0) phase_d = next_part(PART_NAME, base_flags);
          end
          PH_COMMENT: begin
            if (b == '0) phase_d = next_part(PART_COMMENT, base_flags);
          end
          PH_HCRC0: phase_d = PH_HCRC1;
          PH_HCRC1: phase_d = PH_DONE;
          default:  phase_d = PH_DONE;
        endcase
        // Reaching the end of the header is what completes it.
        if (phase_d == PH_DONE) outcome_d = gzhp_pkg::ST_COMPLETE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MAGIC0;
      skip_q    <= '0;
      flags_q   <= '0;
      len_low_q <= '0;
      outcome_q <= gzhp_pkg::ST_MORE;
    end else if (req_i.fire) begin
      phase_q   <= phase_d;
      skip_q    <= skip_d;
      flags_q   <= flags_d;
      len_low_q <= len_low_d;
      outcome_q <= outcome_d;
    end
  end

  assign result_o.status       = outcome_d;
  assign result_o.header_flags = flags_d;

  // A final status holds until a begin request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outcome_q != gzhp_pkg::ST_MORE && req_i.fire && !req_i.item.begin_req) |=>
      $stable(outcome_q) && $stable(flags_q))
    else $error("final status changed without a begin request");

  // Complete goes with the done phase, and only with it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) == (outcome_q == gzhp_pkg::ST_COMPLETE))
    else $error("done phase and complete status disagree");

  // Skipping the fixed bytes never runs past its count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FIXED) |-> (skip_q != '0 && skip_q <= gzhp_pkg::FixedBytes))
    else $error("fixed byte counter out of range");

endmodule
